>>> src/sha256_stream_hasher_defines.svh
// Assertion macros used by the checker file of the hasher.
`ifndef SHA256_STREAM_HASHER_DEFINES_SVH
`define SHA256_STREAM_HASHER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define SHASH_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hasher port check failed");

// Consequent in the cycle after the antecedent.
`define SHASH_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hasher port check failed");

`endif

>>> src/shash_pkg.sv
package shash_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MARK,
		ST_ZERO,
		ST_LEN,
		ST_ROUND,
		ST_ADD,
		ST_DONE
	} state_t;

	// What the sequencer does once a block has been compressed.
	typedef enum logic [1:0] {
		BK_DATA,
		BK_PAD,
		BK_FINAL
	} blk_kind_t;

	typedef struct packed {
		logic byte_en;
		logic load;
		logic step;
		logic add;
		logic init;
	} core_ctl_t;

	localparam logic [1:0] OP_ABSORB        = 2'd0;
	localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
	localparam logic [1:0] OP_FINISH        = 2'd2;

	localparam logic [5:0]  FILL_LAST    = 6'd63;
	localparam logic [5:0]  LEN_POS      = 6'd56;
	localparam logic [5:0]  ROUND_LAST   = 6'd63;
	localparam logic [7:0]  PAD_MARK     = 8'h80;
	localparam logic [63:0] BLOCK_BITS   = 64'd512;
	localparam logic [3:0]  DIGEST_WORDS = 4'd8;
	localparam logic [2:0]  LAST_INDEX   = 3'd7;

	// Index 0 holds the first hash word.
	localparam logic [7:0][31:0] IV = {
		32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
		32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] ssig0(input logic [31:0] x);
		return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
	endfunction

	function automatic logic [31:0] ssig1(input logic [31:0] x);
		return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
	endfunction

	function automatic logic [31:0] bsig0(input logic [31:0] x);
		return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
	endfunction

	function automatic logic [31:0] bsig1(input logic [31:0] x);
		return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
	endfunction

endpackage

>>> src/shash_sched.sv
module shash_sched (
	input  logic                 clk,
	input  shash_pkg::core_ctl_t ctl,
	input  logic [7:0]           byte_in,
	output logic [31:0]          wt
);
	import shash_pkg::*;

	// Sixteen-word window; word 15 is the oldest. Bytes enter at the bottom,
	// so after a full block word 15 holds the first four message bytes.
	logic [15:0][31:0] win_q;
	logic [31:0]       w_new;

	assign wt    = win_q[15];
	assign w_new = ssig1(win_q[1]) + win_q[6] + ssig0(win_q[14]) + win_q[15];

	always_ff @(posedge clk) begin
		if (ctl.byte_en) begin
			win_q <= {win_q[15][23:0], win_q[14:0], byte_in};
		end else if (ctl.step) begin
			win_q <= {win_q[14:0], w_new};
		end
	end

endmodule

>>> src/shash_round.sv
module shash_round (
	input  logic                 clk,
	input  logic                 arst_n,
	input  shash_pkg::core_ctl_t ctl,
	input  logic [31:0]          kt,
	input  logic [31:0]          wt,
	output logic [7:0][31:0]     hash
);
	import shash_pkg::*;

	// Working variables a through h sit at indexes 0 through 7.
	logic [7:0][31:0] hash_q;
	logic [7:0][31:0] v_q;
	logic [31:0]      ch;
	logic [31:0]      maj;
	logic [31:0]      t1;
	logic [31:0]      t2;

	assign hash = hash_q;
	assign ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
	assign maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
	assign t1   = v_q[7] + bsig1(v_q[4]) + ch + kt + wt;
	assign t2   = bsig0(v_q[0]) + maj;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= IV;
		end else if (ctl.init) begin
			hash_q <= IV;
		end else if (ctl.add) begin
			for (int i = 0; i < 8; i++) begin
				hash_q[i] <= hash_q[i] + v_q[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			v_q <= hash_q;
		end else if (ctl.step) begin
			v_q <= {v_q[6:4], v_q[3] + t1, v_q[2:0], t1 + t2};
		end
	end

endmodule

>>> src/sha256_stream_hasher.sv
// Channel | Handshake                  | Payload
// item    | item_valid / item_stall    | operation[1:0], data_byte[7:0]
// digest  | digest_valid / digest_stall| digest_word[31:0], word_index[2:0], last_word
//
// An absorbed byte is taken while idle; the byte that completes a block starts 64 rounds
// on the single round unit and then a fold into the hash words, while the item channel stalls.
// A finish pads with the 0x80 mark, zero bytes and the 64-bit length, adding a further block
// when 56 or more bytes are pending, and then hands off the digest.
// The digest drains from its own register, so a stalled digest only holds the next finish back.
// arst_n clears the sequencer, counters and hash words to the initial values.
module sha256_stream_hasher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [1:0]  operation,
	input  logic [7:0]  data_byte,
	output logic        digest_valid,
	input  logic        digest_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);
	import shash_pkg::*;

	state_t           state_q, state_d;
	blk_kind_t        kind_q, kind_d;
	logic             fin_q, fin_d;
	logic [5:0]       fill_q, fill_d;
	logic [5:0]       rnd_q, rnd_d;
	logic [63:0]      bits_q, bits_d;
	logic [63:0]      len_q, len_d;
	core_ctl_t        ctl;
	logic [7:0]       sched_byte;
	logic             dig_load;
	logic             in_acc;
	logic             out_acc;
	logic [31:0]      wt;
	logic [7:0][31:0] hash;
	logic [7:0][31:0] dig_q;
	logic [3:0]       out_cnt_q;
	logic [2:0]       idx_q;

	// The message window doubles as the block buffer: bytes shift straight into it,
	// and the schedule then rolls it forward one word per round.
	shash_sched u_sched (
		.clk     (clk),
		.ctl     (ctl),
		.byte_in (sched_byte),
		.wt      (wt)
	);

	shash_round u_round (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.kt     (ROUND_K[rnd_q]),
		.wt     (wt),
		.hash   (hash)
	);

	assign item_stall = (state_q != ST_IDLE);
	assign in_acc     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q  <= BK_DATA;
			fin_q   <= 1'b0;
			fill_q  <= '0;
			rnd_q   <= '0;
			bits_q  <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			kind_q  <= kind_d;
			fin_q   <= fin_d;
			fill_q  <= fill_d;
			rnd_q   <= rnd_d;
			bits_q  <= bits_d;
			len_q   <= len_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		kind_d     = kind_q;
		fin_d      = fin_q;
		fill_d     = fill_q;
		rnd_d      = rnd_q;
		bits_d     = bits_q;
		len_d      = len_q;
		ctl        = '0;
		sched_byte = data_byte;
		dig_load   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					if (operation == OP_ABSORB || operation == OP_ABSORB_FINISH) begin
						ctl.byte_en = 1'b1;
						fill_d      = fill_q + 6'd1;
						fin_d       = (operation == OP_ABSORB_FINISH);
						if (fill_q == FILL_LAST) begin
							// A full block of message bytes: count it and compress.
							state_d  = ST_ROUND;
							kind_d   = BK_DATA;
							ctl.load = 1'b1;
							bits_d   = bits_q + BLOCK_BITS;
						end else if (operation == OP_ABSORB_FINISH) begin
							state_d = ST_MARK;
						end
					end else if (operation == OP_FINISH) begin
						state_d = ST_MARK;
					end
				end
			end
			ST_MARK: begin
				// The message length is fixed here, before any padding enters.
				len_d       = bits_q + {55'd0, fill_q, 3'b000};
				fin_d       = 1'b0;
				ctl.byte_en = 1'b1;
				sched_byte  = PAD_MARK;
				fill_d      = fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					state_d  = ST_ROUND;
					kind_d   = BK_PAD;
					ctl.load = 1'b1;
				end else begin
					state_d = ST_ZERO;
				end
			end
			ST_ZERO: begin
				if (fill_q == LEN_POS) begin
					state_d = ST_LEN;
				end else begin
					ctl.byte_en = 1'b1;
					sched_byte  = 8'd0;
					fill_d      = fill_q + 6'd1;
					if (fill_q == FILL_LAST) begin
						// No room for the length: this block goes out without it.
						state_d  = ST_ROUND;
						kind_d   = BK_PAD;
						ctl.load = 1'b1;
					end
				end
			end
			ST_LEN: begin
				ctl.byte_en = 1'b1;
				sched_byte  = len_q[63:56];
				len_d       = {len_q[55:0], 8'd0};
				fill_d      = fill_q + 6'd1;
				if (fill_q == FILL_LAST) begin
					state_d  = ST_ROUND;
					kind_d   = BK_FINAL;
					ctl.load = 1'b1;
				end
			end
			ST_ROUND: begin
				ctl.step = 1'b1;
				rnd_d    = rnd_q + 6'd1;
				if (rnd_q == ROUND_LAST) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				ctl.add = 1'b1;
				unique case (kind_q)
					BK_DATA:  state_d = fin_q ? ST_MARK : ST_IDLE;
					BK_PAD:   state_d = ST_ZERO;
					BK_FINAL: state_d = ST_DONE;
					default:  state_d = ST_IDLE;
				endcase
			end
			ST_DONE: begin
				// Wait until the previous digest has fully drained.
				if (out_cnt_q == 4'd0) begin
					dig_load = 1'b1;
					ctl.init = 1'b1;
					bits_d   = '0;
					fill_d   = '0;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Digest output register: eight words, word 0 shown first.
	assign digest_valid = (out_cnt_q != 4'd0);
	assign out_acc      = digest_valid && !digest_stall;
	assign digest_word  = dig_q[0];
	assign word_index   = idx_q;
	assign last_word    = (idx_q == LAST_INDEX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_cnt_q <= '0;
			idx_q     <= '0;
		end else if (dig_load) begin
			out_cnt_q <= DIGEST_WORDS;
			idx_q     <= '0;
		end else if (out_acc) begin
			out_cnt_q <= out_cnt_q - 4'd1;
			idx_q     <= idx_q + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (dig_load) begin
			dig_q <= hash;
		end else if (out_acc) begin
			dig_q <= {32'd0, dig_q[7:1]};
		end
	end

endmodule

>>> src/shash_checker.sv
`include "sha256_stream_hasher_defines.svh"

module shash_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_stall,
	input logic [1:0]  operation,
	input logic        digest_valid,
	input logic        digest_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  word_index,
	input logic        last_word
);
	import shash_pkg::*;

	logic        dig_hold;
	logic        dig_step;
	logic        fin_take;
	logic [34:0] dig_view;
	logic [2:0]  idx_inc;

	assign dig_hold = digest_valid && digest_stall;
	assign dig_step = digest_valid && !digest_stall && !last_word;
	assign fin_take = item_valid && !item_stall
		&& (operation == OP_ABSORB_FINISH || operation == OP_FINISH);
	assign dig_view = {digest_word, word_index};
	assign idx_inc  = word_index + 3'd1;

	`SHASH_ASSERT_NEXT(a_digest_hold, dig_hold, digest_valid && $stable(dig_view))
	`SHASH_ASSERT_NOW(a_last_index, digest_valid && last_word, word_index == LAST_INDEX)
	`SHASH_ASSERT_NEXT(a_word_order, dig_step, digest_valid && word_index == $past(idx_inc))
	`SHASH_ASSERT_NEXT(a_finish_busy, fin_take, item_stall)

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (.*);
